@@ design/utl_pkg.sv @@
// Shared constants, types and register codes of the uniform table interpolator.
package utl_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = 9;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  localparam cfg_idx_t REG_X_LOW = 2'd0;
  localparam cfg_idx_t REG_INV_STEP = 2'd1;
  localparam cfg_idx_t REG_ENTRY_COUNT = 2'd2;

  localparam logic [VAL_W-1:0] INV_STEP_RESET = 32'h0001_0000;
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 9'd2;
  localparam logic [CNT_W-1:0] TABLE_DEPTH_CNT = CNT_W'(TABLE_DEPTH);

endpackage

@@ design/utl_in_if.sv @@
// Request channel of the interpolator: table loads and evaluations.
interface utl_in_if;
  import utl_pkg::*;

  logic valid;
  logic ready;
  cmd_e cmd;
  idx_t entry_index;
  val_t entry_value;
  val_t x_in;

  modport source (output valid, cmd, entry_index, entry_value, x_in, input ready);
  modport sink (input valid, cmd, entry_index, entry_value, x_in, output ready);
endinterface

@@ design/utl_out_if.sv @@
// Result channel of the interpolator.
interface utl_out_if;
  import utl_pkg::*;

  logic valid;
  logic ready;
  val_t result_value;
  logic out_of_range;

  modport source (output valid, result_value, out_of_range, input ready);
  modport sink (input valid, result_value, out_of_range, output ready);
endinterface

@@ design/uniform_table_lerp_core.sv @@
// Linear interpolation in a table of evenly spaced samples, six-stage pipeline.
//
//   channel  direction  handshake            payload
//   req_i    in         valid / ready        cmd, entry_index, entry_value, x_in
//   rsp_o    out        valid / ready        result_value, out_of_range
//   cfg      in         cfg_valid_i / ready  cfg_index_i, cfg_data_i
//
// One request enters per cycle unless stalled; an evaluate result passes through s1
// to s5 and the output register, which hold the two multipliers and the registered
// table read. Loads give no result. The whole pipeline stalls while the output holds
// an untaken result, so nothing is dropped or repeated. Reset clears the valid bits
// and presets the config registers; the table holds no reset value until loaded.
module uniform_table_lerp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  utl_in_if.sink              req_i,
  utl_out_if.source           rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  utl_pkg::cfg_idx_t   cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import utl_pkg::*;

  localparam logic signed [VAL_W+2:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [VAL_W+2:0] SAT_MIN = -35'sd2147483648;

  val_t               x_low_q;
  logic [VAL_W-1:0]   inv_step_q;
  logic [CNT_W-1:0]   entry_count_q;

  logic               advance;
  logic [VAL_W:0]     diff_in;
  logic               neg_in;

  logic               s1_valid_q;
  cmd_e               s1_cmd_q;
  idx_t               s1_idx_q;
  val_t               s1_val_q;
  logic [VAL_W-1:0]   s1_d_q;
  logic               s1_neg_q;

  logic [63:0]        pos_full;
  logic               s2_valid_q;
  cmd_e               s2_cmd_q;
  idx_t               s2_idx_q;
  val_t               s2_val_q;
  logic               s2_neg_q;
  logic [47:0]        s2_pos_q;

  logic [31:0]        pos_idx;
  logic [CNT_W-1:0]   cnt_eff;
  logic               span_oor;
  idx_t               addr0;
  idx_t               addr1;
  val_t               table_mem [TABLE_DEPTH];
  val_t               rd0_q;
  val_t               rd1_q;
  logic               s3_valid_q;
  logic               s3_oor_q;
  logic [FRAC_W-1:0]  s3_frac_q;

  logic               s4_valid_q;
  logic               s4_oor_q;
  logic [FRAC_W-1:0]  s4_frac_q;
  val_t               s4_v0_q;
  logic signed [VAL_W:0] s4_diff_q;

  logic               s5_valid_q;
  logic               s5_oor_q;
  val_t               s5_v0_q;
  logic signed [VAL_W+FRAC_W+1:0] s5_prod_q;

  logic signed [VAL_W+1:0] step_val;
  logic signed [VAL_W+2:0] sum_val;
  val_t               res_val;

  logic               rsp_valid_q;
  val_t               rsp_value_q;
  logic               rsp_oor_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q       <= '0;
      inv_step_q    <= INV_STEP_RESET;
      entry_count_q <= ENTRY_COUNT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_X_LOW:       x_low_q <= cfg_data_i;
        REG_INV_STEP:    inv_step_q <= cfg_data_i;
        REG_ENTRY_COUNT: entry_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = advance;

  assign diff_in = {req_i.x_in[VAL_W-1], req_i.x_in} - {x_low_q[VAL_W-1], x_low_q};
  assign neg_in  = diff_in[VAL_W] && (inv_step_q != '0);

  assign pos_full = 64'(s1_d_q) * 64'(inv_step_q);

  assign pos_idx  = s2_pos_q[47:16];
  assign cnt_eff  = (entry_count_q > TABLE_DEPTH_CNT) ? TABLE_DEPTH_CNT : entry_count_q;
  assign span_oor = (|pos_idx[31:IDX_W]) ||
                    (((CNT_W+1)'(pos_idx[IDX_W-1:0]) + (CNT_W+1)'(2)) > (CNT_W+1)'(cnt_eff));
  assign addr0    = pos_idx[IDX_W-1:0];
  assign addr1    = addr0 + idx_t'(1);

  assign step_val = s5_prod_q[VAL_W+FRAC_W+1:FRAC_W];
  assign sum_val  = {{3{s5_v0_q[VAL_W-1]}}, s5_v0_q} + {step_val[VAL_W+1], step_val};

  always_comb begin
    if (sum_val > SAT_MAX) begin
      res_val = SAT_MAX[VAL_W-1:0];
    end else if (sum_val < SAT_MIN) begin
      res_val = SAT_MIN[VAL_W-1:0];
    end else begin
      res_val = sum_val[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= req_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q && (s2_cmd_q == CMD_EVAL);
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      rsp_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_cmd_q  <= req_i.cmd;
      s1_idx_q  <= req_i.entry_index;
      s1_val_q  <= req_i.entry_value;
      s1_d_q    <= diff_in[VAL_W-1:0];
      s1_neg_q  <= neg_in;

      s2_cmd_q  <= s1_cmd_q;
      s2_idx_q  <= s1_idx_q;
      s2_val_q  <= s1_val_q;
      s2_neg_q  <= s1_neg_q;
      s2_pos_q  <= pos_full[63:16];

      s3_oor_q  <= s2_neg_q || span_oor;
      s3_frac_q <= s2_pos_q[FRAC_W-1:0];

      s4_oor_q  <= s3_oor_q;
      s4_frac_q <= s3_frac_q;
      s4_v0_q   <= rd0_q;
      s4_diff_q <= $signed({rd1_q[VAL_W-1], rd1_q}) - $signed({rd0_q[VAL_W-1], rd0_q});

      s5_oor_q  <= s4_oor_q;
      s5_v0_q   <= s4_v0_q;
      s5_prod_q <= s4_diff_q * $signed({1'b0, s4_frac_q});

      rsp_oor_q   <= s5_oor_q;
      rsp_value_q <= s5_oor_q ? '0 : res_val;
    end
  end

  // Loads write in the same stage where evaluations read, which keeps request order.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (s2_valid_q && (s2_cmd_q == CMD_LOAD)) begin
        table_mem[s2_idx_q] <= s2_val_q;
      end
      rd0_q <= table_mem[addr0];
      rd1_q <= table_mem[addr1];
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_value = rsp_value_q;
  assign rsp_o.out_of_range = rsp_oor_q;

endmodule

@@ design/utl_checker.sv @@
// Port-level assertions for the interpolator and their binding to the top level.
module utl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_value_i,
  input logic        out_oor_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_oor_i))
    else $error("Stalled result changed or vanished.");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_oor_i |-> out_value_i == 32'd0)
    else $error("Out-of-range result carries a nonzero value.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("Request refused while the output stage is empty.");

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("Request accepted while the pipeline is stalled.");

endmodule

bind uniform_table_lerp_core utl_checker u_utl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_value_i (rsp_o.result_value),
  .out_oor_i   (rsp_o.out_of_range)
);
